@@ design/tct_pkg.sv @@
// Shared item types, control codes and byte-operation flags of the text console.
`timescale 1ns / 1ps

package tct_pkg;

    localparam logic [7:0] CH_BS       = 8'd8;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_FF       = 8'd12;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd126;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CELL_ATTR   = 8'h0F;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_linear;
        logic [15:0] cell_word;
    } t_out_item;

    // Side effects of one character byte on the screen memory
    typedef struct packed {
        logic wr_char;
        logic scroll;
        logic clear;
    } t_byte_ops;

endpackage

@@ design/tct_screen_ram.sv @@
// Character screen memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tct_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tct_cursor.sv @@
// Cursor update and memory side effects for one character byte.
`timescale 1ns / 1ps

module tct_cursor #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STEP = 8,
    parameter int RW       = 5,
    parameter int CW       = 7
) (
    input  logic [RW-1:0]     i_row,
    input  logic [CW-1:0]     i_col,
    input  logic [7:0]        i_code,
    output logic [RW-1:0]     o_row,
    output logic [CW-1:0]     o_col,
    output tct_pkg::t_byte_ops o_ops
);
    import tct_pkg::*;

    localparam int NCOL = 1 << CW;

    typedef logic [NCOL-1:0][CW-1:0] t_tab;

    // next tab stop for each column, clipped to the last column
    function automatic t_tab f_tab_stops();
        t_tab t;
        int   stop;
        stop = TAB_STEP;
        for (int c = 0; c < NCOL; c++) begin
            if (c >= stop) begin
                stop = stop + TAB_STEP;
            end
            t[c] = CW'((stop < COLS - 1) ? stop : COLS - 1);
        end
        return t;
    endfunction

    localparam t_tab TAB_STOPS = f_tab_stops();

    logic last_col;
    logic last_row;

    assign last_col = (i_col == CW'(COLS - 1));
    assign last_row = (i_row == RW'(ROWS - 1));

    always_comb begin
        o_row = i_row;
        o_col = i_col;
        o_ops = '0;
        case (i_code) inside
            [CH_PRINT_LO:CH_PRINT_HI]: begin
                o_ops.wr_char = 1'b1;
                if (!last_col) begin
                    o_col = i_col + CW'(1);
                end else if (!last_row) begin
                    o_row = i_row + RW'(1);
                    o_col = '0;
                end
            end
            CH_BS: begin
                if (i_col != '0) begin
                    o_col = i_col - CW'(1);
                end else if (i_row != '0) begin
                    o_col = CW'(COLS - 1);
                    o_row = i_row - RW'(1);
                end
            end
            CH_TAB: begin
                if (!last_col) begin
                    o_col = TAB_STOPS[i_col];
                end
            end
            CH_LF: begin
                if (!last_row) begin
                    o_row = i_row + RW'(1);
                end else begin
                    o_ops.scroll = 1'b1;
                end
                o_col = '0;
            end
            CH_FF: begin
                o_ops.clear = 1'b1;
                o_row = '0;
                o_col = '0;
            end
            CH_CR: begin
                o_col = '0;
            end
            default: begin
                o_row = i_row;
            end
        endcase
    end

endmodule

@@ design/text_console_terminal_unit.sv @@
// Top level of the text console: cursor, sequencer and screen memory control.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one item: either a
//   character byte to process (action 0) or a request to read one screen cell
//   (action 1). Every item yields exactly one result item on the output channel
//   (o_out_valid / i_out_ready / o_out_data) holding the cursor after the item
//   and, for an in-range read, the cell word {attribute 0x0F, character}.
//   A printable, control or ignored byte is accepted in the idle state, then
//   its result is loaded into the result register in the emit state; a cell
//   read starts the registered memory read on acceptance and loads the read
//   data in the emit state. Newline on the last row scrolls the screen by
//   walking the single memory write port; form feed clears the screen. The
//   block works on one item at a time; o_in_ready is high only while idle.
//   Reset: after i_rst_n releases, a clearing pass writes spaces to all
//   ROWS*COLS cells with o_in_ready low. The cursor resets to row 0, column 0.
//   Stall: a finished result waits in the output register; the sequencer holds
//   in its emit state until the register frees, then returns to idle.
`timescale 1ns / 1ps

module text_console_terminal_unit #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STEP = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tct_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tct_pkg::t_out_item  o_out_data
);
    import tct_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EMIT   = 5'b00010,
        ST_CLEAR  = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_FILL   = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic            r_boot, n_boot;
    logic            r_mv_valid, n_mv_valid;
    logic [AW-1:0]   r_mv_addr, n_mv_addr;
    logic            r_is_read, n_is_read;
    logic            r_rd_ok, n_rd_ok;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    // memory port controls
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata;

    // cursor update
    logic [RW-1:0]   cur_row;
    logic [CW-1:0]   cur_col;
    t_byte_ops       cur_ops;

    logic            in_acc;
    logic            out_free;
    logic            ptr_last;
    logic            rd_in_range;
    logic [AW-1:0]   cur_addr;
    logic [AW-1:0]   rd_addr;

    tct_cursor #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STEP (TAB_STEP),
        .RW       (RW),
        .CW       (CW)
    ) u_cursor (
        .i_row  (r_row),
        .i_col  (r_col),
        .i_code (i_in_data.char_code),
        .o_row  (cur_row),
        .o_col  (cur_col),
        .o_ops  (cur_ops)
    );

    tct_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign ptr_last    = (r_ptr == AW'(CELLS - 1));
    assign rd_in_range = (int'(i_in_data.read_row) < ROWS) && (int'(i_in_data.read_col) < COLS);
    assign cur_addr    = AW'(int'(r_row) * COLS + int'(r_col));
    assign rd_addr     = AW'(int'(i_in_data.read_row) * COLS + int'(i_in_data.read_col));

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_ptr       = r_ptr;
        n_boot      = r_boot;
        n_mv_valid  = r_mv_valid;
        n_mv_addr   = r_mv_addr;
        n_is_read   = r_is_read;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = CH_SPACE;
        mem_re      = 1'b0;
        mem_raddr   = r_ptr;

        // drain the result register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_is_read = (i_in_data.action == ACT_READ);
                    if (i_in_data.action == ACT_READ) begin
                        // read the cell only if it is on the screen
                        n_rd_ok   = rd_in_range;
                        mem_re    = rd_in_range;
                        mem_raddr = rd_addr;
                        n_state   = ST_EMIT;
                    end else begin
                        n_row     = cur_row;
                        n_col     = cur_col;
                        mem_we    = cur_ops.wr_char;
                        mem_waddr = cur_addr;
                        mem_wdata = i_in_data.char_code;
                        if (cur_ops.scroll) begin
                            n_ptr      = AW'(COLS);
                            n_mv_valid = 1'b0;
                            n_state    = ST_SCROLL;
                        end else if (cur_ops.clear) begin
                            n_ptr   = '0;
                            n_state = ST_CLEAR;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.cursor_row        = 5'(r_row);
                    n_out.cursor_col        = 7'(r_col);
                    n_out.cursor_linear     = 11'(int'(r_row) * COLS + int'(r_col));
                    n_out.cell_word         = (r_is_read && r_rd_ok) ?
                                              {CELL_ATTR, mem_rdata} : 16'h0000;
                    n_state                 = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                // write spaces over the whole screen, one cell a cycle
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = CH_SPACE;
                if (ptr_last) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? ST_IDLE : ST_EMIT;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            ST_SCROLL: begin
                // read a cell one row down, write it one row up next cycle
                mem_re    = 1'b1;
                mem_raddr = r_ptr;
                if (r_mv_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_mv_addr;
                    mem_wdata = mem_rdata;
                end
                n_mv_valid = 1'b1;
                n_mv_addr  = r_ptr - AW'(COLS);
                if (ptr_last) begin
                    n_ptr   = AW'(CELLS - COLS);
                    n_state = ST_FILL;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            ST_FILL: begin
                if (r_mv_valid) begin
                    // finish the last moved cell first
                    mem_we     = 1'b1;
                    mem_waddr  = r_mv_addr;
                    mem_wdata  = mem_rdata;
                    n_mv_valid = 1'b0;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr;
                    mem_wdata = CH_SPACE;
                    if (ptr_last) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_boot      <= 1'b1;
            r_mv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_ptr       <= n_ptr;
            r_boot      <= n_boot;
            r_mv_valid  <= n_mv_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_addr <= n_mv_addr;
        r_is_read <= n_is_read;
        r_rd_ok   <= n_rd_ok;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // no item is taken until the power-up clear is complete
    a_boot_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boot |-> !o_in_ready)
        else $error("item accepted during power-up clear");

    // a scroll only runs with the cursor parked at the start of the last row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL || r_state == ST_FILL) |->
            (r_row == RW'(ROWS - 1) && r_col == '0))
        else $error("cursor moved during scroll");

    // a pending moved cell exists only inside the scroll sequence
    a_move_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv_valid |-> (r_state == ST_SCROLL || r_state == ST_FILL))
        else $error("stray pending move write");

    // a result leaving the emit state is presented on the next cycle
    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("result not loaded on emit");

    // sweep pointer stays inside the screen
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_ptr) < CELLS))
        else $error("sweep pointer out of range");

endmodule

@@ dv/text_console_terminal_unit_test.sv @@
// Self-checking testbench of the text console: cursor motion, scroll, clear and cell reads.
`timescale 1ns / 1ps

module text_console_terminal_unit_test;

    import tct_pkg::*;

    localparam int SCR_ROWS  = 25;
    localparam int SCR_COLS  = 80;
    localparam int SCR_CELLS = SCR_ROWS * SCR_COLS;
    localparam int TAB_WIDTH = 8;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int TAIL_CYCLES    = 20;
    localparam logic [7:0] CH_DEL = 8'd127;

    // Idling modes of the two channels, stepped through as items get accepted
    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_SEND,
        GAP_RECV,
        GAP_BOTH
    } t_gap_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    text_console_terminal_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Items waiting to be offered, and cursor/cell reports waiting to come back
    t_in_item  console_items_q[$];
    t_out_item cursor_reports_q[$];

    // Mirror of the console: screen bytes and cursor
    logic [7:0] screen_mirror [SCR_CELLS];
    logic [4:0] cur_row;
    logic [6:0] cur_col;

    int  items_accepted = 0;
    int  mismatches     = 0;
    int  cycle_budget   = 0;
    logic sink_holdoff  = 1'b0;

    // Apply one item to the mirror and return the report the block should give.
    function automatic t_out_item console_step(input t_in_item it);
        t_out_item res;
        int        nxt;
        res = '0;
        if (it.action == ACT_BYTE) begin
            if (it.char_code >= CH_PRINT_LO && it.char_code <= CH_PRINT_HI) begin
                // Store at the cursor, then advance; the last cell holds the cursor
                screen_mirror[cur_row * SCR_COLS + cur_col] = it.char_code;
                if (cur_col != SCR_COLS - 1) begin
                    cur_col = cur_col + 1'b1;
                end else if (cur_row != SCR_ROWS - 1) begin
                    cur_row = cur_row + 1'b1;
                    cur_col = '0;
                end
            end else begin
                case (it.char_code)
                    CH_BS: begin
                        // Step back, wrapping to the end of the previous row; never erase
                        if (cur_col != 0) begin
                            cur_col = cur_col - 1'b1;
                        end else if (cur_row != 0) begin
                            cur_col = 7'(SCR_COLS - 1);
                            cur_row = cur_row - 1'b1;
                        end
                    end
                    CH_TAB: begin
                        if (cur_col < SCR_COLS - 1) begin
                            nxt = (int'(cur_col) / TAB_WIDTH + 1) * TAB_WIDTH;
                            cur_col = (nxt < SCR_COLS - 1) ? 7'(nxt) : 7'(SCR_COLS - 1);
                        end
                    end
                    CH_LF: begin
                        // On the last row, shift every row up and blank the bottom one
                        if (cur_row != SCR_ROWS - 1) begin
                            cur_row = cur_row + 1'b1;
                        end else begin
                            for (int i = 0; i < SCR_CELLS - SCR_COLS; i++) begin
                                screen_mirror[i] = screen_mirror[i + SCR_COLS];
                            end
                            for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++) begin
                                screen_mirror[i] = CH_SPACE;
                            end
                        end
                        cur_col = '0;
                    end
                    CH_FF: begin
                        for (int i = 0; i < SCR_CELLS; i++) begin
                            screen_mirror[i] = CH_SPACE;
                        end
                        cur_row = '0;
                        cur_col = '0;
                    end
                    CH_CR: begin
                        cur_col = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (it.read_row < SCR_ROWS && it.read_col < SCR_COLS) begin
            res.cell_word = {CELL_ATTR, screen_mirror[it.read_row * SCR_COLS + it.read_col]};
        end
        res.cursor_row    = cur_row;
        res.cursor_col    = cur_col;
        res.cursor_linear = 11'(cur_row * SCR_COLS + cur_col);
        return res;
    endfunction

    function automatic t_gap_mode gap_mode(input int accepted);
        case ((accepted / 210) % 5)
            1:       return GAP_SEND;
            2:       return GAP_RECV;
            3:       return GAP_BOTH;
            default: return GAP_NONE;
        endcase
    endfunction

    // Byte items carry random read fields so that every bit of them toggles
    task automatic push_byte(input logic [7:0] code);
        t_in_item it;
        it.action    = ACT_BYTE;
        it.char_code = code;
        it.read_row  = 5'($urandom);
        it.read_col  = 7'($urandom);
        console_items_q.push_back(it);
    endtask

    task automatic push_read(input int row, input int col);
        t_in_item it;
        it.action    = ACT_READ;
        it.char_code = 8'($urandom);
        it.read_row  = 5'(row);
        it.read_col  = 7'(col);
        console_items_q.push_back(it);
    endtask

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    endfunction

    // Pick a byte outside the printable range that no control code claims
    function automatic logic [7:0] ignored_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= CH_PRINT_LO && b <= CH_PRINT_HI) || b == CH_BS || b == CH_TAB
                   || b == CH_LF || b == CH_FF || b == CH_CR);
        return b;
    endfunction

    // Feed items: take the item at a handshake, then offer the next one unless idling.
    always @(posedge i_clk) begin
        int send_idle;
        send_idle = 0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            case (gap_mode(items_accepted))
                GAP_SEND: send_idle = 86;
                GAP_BOTH: send_idle = 9;
                default:  send_idle = 0;
            endcase
            if (i_in_valid && o_in_ready) begin
                cursor_reports_q.push_back(console_step(i_in_data));
                items_accepted <= items_accepted + 1;
            end
            // Hold an unaccepted item as it is; otherwise the slot is free
            if (!i_in_valid || o_in_ready) begin
                if (console_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_in_data  <= console_items_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Collect reports, compare with the oldest expectation, then pick the next ready.
    always @(posedge i_clk) begin
        t_out_item want;
        int        recv_stall;
        recv_stall = 0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (cursor_reports_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("unexpected report: row %0d col %0d linear %0d cell %h",
                                 o_out_data.cursor_row, o_out_data.cursor_col,
                                 o_out_data.cursor_linear, o_out_data.cell_word);
                    end
                    mismatches++;
                end else begin
                    want = cursor_reports_q.pop_front();
                    if (o_out_data.cursor_row != want.cursor_row
                        || o_out_data.cursor_col != want.cursor_col
                        || o_out_data.cursor_linear != want.cursor_linear
                        || o_out_data.cell_word != want.cell_word) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("mismatch: exp row %0d col %0d linear %0d cell %h",
                                     want.cursor_row, want.cursor_col,
                                     want.cursor_linear, want.cell_word);
                            $display("          got row %0d col %0d linear %0d cell %h",
                                     o_out_data.cursor_row, o_out_data.cursor_col,
                                     o_out_data.cursor_linear, o_out_data.cell_word);
                        end
                        mismatches++;
                    end
                end
            end
            case (gap_mode(items_accepted))
                GAP_RECV: recv_stall = 86;
                GAP_BOTH: recv_stall = 9;
                default:  recv_stall = 0;
            endcase
            i_out_ready <= !sink_holdoff && ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Long hold-off on the result side while items keep coming, so the input backs up
    initial begin
        wait (items_accepted >= 40);
        @(posedge i_clk);
        sink_holdoff <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        sink_holdoff <= 1'b0;
    end

    // Abort a hung run; the budget covers a scroll or clear on every newline and form feed
    initial begin
        int n;
        wait (i_rst_n);
        for (n = 0; n < cycle_budget; n++) begin
            @(posedge i_clk);
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int pick;
        int len;
        int row;
        for (int i = 0; i < SCR_CELLS; i++) begin
            screen_mirror[i] = CH_SPACE;
        end
        cur_row = '0;
        cur_col = '0;

        // Directed: reads at the corners and out of range, cursor edges, ignored bytes
        push_read(0, 0);
        push_read(SCR_ROWS - 1, SCR_COLS - 1);
        push_read(31, 127);
        push_read(SCR_ROWS, 3);
        push_read(2, SCR_COLS);
        push_byte(CH_BS);               // backspace at home does nothing
        push_byte(CH_PRINT_LO);
        push_byte(CH_PRINT_HI);
        push_byte(8'h41);
        push_read(0, 1);
        push_byte(CH_TAB);
        push_byte(CH_BS);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_BS);               // column 0 wraps to the end of the row above
        push_byte(8'h7A);               // last column wraps to the next row
        push_read(0, SCR_COLS - 1);
        push_byte(8'd0);
        push_byte(CH_DEL);
        push_byte(8'd255);
        push_byte(8'd11);
        push_byte(CH_FF);
        push_read(0, 1);

        // Random: text bursts broken by control bytes, reads and noise
        while (console_items_q.size() < RANDOM_ITEMS + 23) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 85)
                                                  : $urandom_range(1, 12);
                repeat (len) push_byte(any_printable());
            end else if (pick < 47) begin
                push_byte(CH_LF);
            end else if (pick < 53) begin
                push_byte(CH_CR);
            end else if (pick < 61) begin
                // Tab runs reach the last column, a printable there may hit the last cell
                repeat ($urandom_range(1, 11)) push_byte(CH_TAB);
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(any_printable());
                end
            end else if (pick < 68) begin
                repeat ($urandom_range(1, 4)) push_byte(CH_BS);
            end else if (pick < 86) begin
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 1) == 1) begin
                        push_read($urandom_range(SCR_ROWS, 31), $urandom_range(0, 127));
                    end else begin
                        push_read($urandom_range(0, 31), $urandom_range(SCR_COLS, 127));
                    end
                end else begin
                    // Favor the bottom row, where most of the text lands
                    row = ($urandom_range(0, 9) < 4) ? SCR_ROWS - 1
                                                     : $urandom_range(0, SCR_ROWS - 1);
                    push_read(row, $urandom_range(0, SCR_COLS - 1));
                end
            end else if (pick < 95) begin
                push_byte(ignored_byte());
            end else if (pick < 97) begin
                push_byte(CH_FF);
            end else begin
                len = $urandom_range(0, SCR_COLS - 8);
                for (int c = len; c < len + 8; c++) begin
                    push_read(SCR_ROWS - 1, c);
                end
            end
        end

        // Budget: reset clearing pass, hold-off, and a slow path for every item
        cycle_budget = SCR_CELLS + HOLDOFF_CYCLES + 1000;
        foreach (console_items_q[i]) begin
            if (console_items_q[i].action == ACT_BYTE
                && (console_items_q[i].char_code == CH_LF
                    || console_items_q[i].char_code == CH_FF)) begin
                cycle_budget += SCR_CELLS + 100;
            end else begin
                cycle_budget += 64;
            end
        end
        cycle_budget *= 4;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything offered, accepted and answered
        while (console_items_q.size() != 0 || i_in_valid || cursor_reports_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && cursor_reports_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
